// ===== hw/rtl/dsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types, widths and codes for the diverse square root voter.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 16;
    localparam int RAD_W     = INT_BITS + FRAC_BITS;      // radicand width
    localparam int S_W       = RAD_W + FRAC_BITS;         // scaled radicand
    localparam int ROOT_W    = 25;                        // result root width
    localparam int BIS_W     = RAD_W + 1;                 // bisection bounds
    localparam int HALF_W    = S_W / 2;                   // narrow multiply
    localparam int TOL_W     = 16;
    localparam int CAP_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int DCNT_W    = $clog2(S_W);

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWTON_CAP = 1'd1;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd32;

    typedef enum logic [1:0] {
        V_REFERENCE = 2'd0,
        V_NEWTON    = 2'd1,
        V_FAULT     = 2'd2
    } t_verdict;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_BIS_MID,
        ST_BIS_MUL,
        ST_BIS_UPD,
        ST_DIV_START,
        ST_DIV,
        ST_NT_NEXT,
        ST_NT_CHK,
        ST_SQUARE,
        ST_VOTE
    } t_state;

    typedef struct packed {
        logic load;
        logic rt_step;
        logic bis_mid;
        logic bis_mul;
        logic bis_upd;
        logic dv_start;
        logic dv_step;
        logic nt_next;
        logic nt_adv;
        logic sq;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic rt_last;
        logic bis_more;
        logic dv_last;
        logic nt_more;
    } t_sts;

    typedef struct packed {
        logic [ROOT_W-1:0] chosen_root;
        logic [ROOT_W-1:0] reference_root;
        logic [ROOT_W-1:0] newton_root;
        logic [ROOT_W-1:0] bisection_root;
        t_verdict          verdict;
        logic              square_check_ok;
    } t_result;

    function automatic logic [BIS_W-1:0] absdiff(input logic [BIS_W-1:0] a,
                                                 input logic [BIS_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== hw/rtl/dsv_in_if.sv =====
// ----------------------------------------------------------------------------
// dsv_in_if
// Radicand channel: valid/ready handshake with one unsigned Q16.16 value.
// ----------------------------------------------------------------------------
interface dsv_in_if;
    import dsv_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAD_W-1:0] radicand;

    modport source(output valid, output radicand, input ready);
    modport sink(input valid, input radicand, output ready);
endinterface

// ===== hw/rtl/dsv_out_if.sv =====
// ----------------------------------------------------------------------------
// dsv_out_if
// Result channel: voted root, the three candidate roots and the flags.
// ----------------------------------------------------------------------------
interface dsv_out_if;
    import dsv_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] chosen_root;
    logic [ROOT_W-1:0] reference_root;
    logic [ROOT_W-1:0] newton_root;
    logic [ROOT_W-1:0] bisection_root;
    logic [1:0]        verdict;
    logic              square_check_ok;

    modport source(output valid, output chosen_root, output reference_root,
                   output newton_root, output bisection_root, output verdict,
                   output square_check_ok, input ready);
    modport sink(input valid, input chosen_root, input reference_root,
                 input newton_root, input bisection_root, input verdict,
                 input square_check_ok, output ready);
endinterface

// ===== hw/rtl/dsv_dp.sv =====
// ----------------------------------------------------------------------------
// dsv_dp
// Datapath: digit-by-digit root, bisection, Newton with a radix-2 divider,
// square check, vote and result register.
// ----------------------------------------------------------------------------
module dsv_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dsv_pkg::t_cmd                  i_cmd,
    output dsv_pkg::t_sts                  o_sts,
    input  logic [dsv_pkg::RAD_W-1:0]      i_radicand,
    input  logic                           i_cfg_we,
    input  logic [dsv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dsv_pkg::CFG_W-1:0]      i_cfg_data,
    output dsv_pkg::t_result               o_res
);
    import dsv_pkg::*;

    // configuration
    logic [TOL_W-1:0]  r_tol;
    logic [CAP_W-1:0]  r_cap;
    logic [TOL_W-1:0]  tol_eff;

    logic [S_W-1:0]    r_s;

    // digit-by-digit root
    logic [S_W:0]      r_rt_res;
    logic [S_W-1:0]    r_rt_rem;
    logic [S_W-1:0]    r_rt_bit;
    logic [S_W:0]      rt_sum;

    // bisection
    logic [BIS_W-1:0]  r_lo;
    logic [BIS_W-1:0]  r_hi;
    logic [BIS_W-1:0]  r_mid;
    logic [S_W-1:0]    r_prod;
    logic              r_mid_big;
    logic [BIS_W:0]    mid_sum;
    logic [BIS_W-1:0]  hi_init;

    // Newton and divider
    logic [S_W-1:0]    r_cur;
    logic [S_W-1:0]    r_next;
    logic [CAP_W-1:0]  r_nt_cnt;
    logic [S_W-1:0]    r_dv_rem;
    logic [S_W-1:0]    r_dv_q;
    logic [DCNT_W-1:0] r_dv_cnt;
    logic [S_W:0]      dv_trial;
    logic [S_W:0]      dv_diff;
    logic [S_W-1:0]    q_eff;
    logic [S_W:0]      nt_sum;
    logic [S_W-1:0]    nt_delta;

    // square check and vote
    logic [ROOT_W-1:0]   n_sat;
    logic [ROOT_W-1:0]   r_nsat;
    logic [2*ROOT_W-1:0] r_nsq;
    logic [2*ROOT_W-1:0] sq_diff;
    logic [BIS_W-1:0]    ref_w;
    logic [BIS_W-1:0]    nt_w;
    logic                rn_ok;
    logic                rb_ok;
    logic                nb_ok;
    t_result             res_d;
    t_result             r_res;

    assign tol_eff = (r_tol == '0) ? TOL_W'(1) : r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOLERANCE:  r_tol <= i_cfg_data[TOL_W-1:0];
                CFG_NEWTON_CAP: r_cap <= i_cfg_data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign hi_init  = {1'b0, i_radicand} + (BIS_W'(1) << FRAC_BITS);
    assign rt_sum   = r_rt_res + {1'b0, r_rt_bit};
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign dv_trial = {r_dv_rem, r_dv_q[S_W-1]};
    assign dv_diff  = dv_trial - {1'b0, r_cur};
    assign q_eff    = (r_cur == '0) ? '0 : r_dv_q;
    assign nt_sum   = {1'b0, r_cur} + {1'b0, q_eff};
    assign nt_delta = (r_next > r_cur) ? (r_next - r_cur) : (r_cur - r_next);
    assign n_sat    = (|r_cur[S_W-1:ROOT_W]) ? {ROOT_W{1'b1}} : r_cur[ROOT_W-1:0];

    assign o_sts.rt_last  = (r_rt_bit == S_W'(1));
    assign o_sts.bis_more = ((r_hi - r_lo) > BIS_W'(tol_eff));
    assign o_sts.dv_last  = (r_dv_cnt == DCNT_W'(S_W - 1));
    assign o_sts.nt_more  = (nt_delta > S_W'(tol_eff)) && (r_nt_cnt < r_cap);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s      <= {i_radicand, FRAC_BITS'(0)};
            r_rt_res <= '0;
            r_rt_rem <= {i_radicand, FRAC_BITS'(0)};
            r_rt_bit <= S_W'(1) << (S_W - 2);
            r_lo     <= '0;
            r_hi     <= hi_init;
            r_cur    <= S_W'(hi_init[BIS_W-1:1]);
            r_nt_cnt <= CAP_W'(1);
        end
        if (i_cmd.rt_step) begin
            if ({1'b0, r_rt_rem} >= rt_sum) begin
                r_rt_rem <= r_rt_rem - rt_sum[S_W-1:0];
                r_rt_res <= (r_rt_res >> 1) + {1'b0, r_rt_bit};
            end else begin
                r_rt_res <= r_rt_res >> 1;
            end
            r_rt_bit <= r_rt_bit >> 2;
        end
        if (i_cmd.bis_mid) begin
            r_mid <= mid_sum[BIS_W:1];
        end
        if (i_cmd.bis_mul) begin
            r_prod    <= r_mid[HALF_W-1:0] * r_mid[HALF_W-1:0];
            r_mid_big <= |r_mid[BIS_W-1:HALF_W];
        end
        if (i_cmd.bis_upd) begin
            if (!r_mid_big && (r_prod <= r_s)) begin
                r_lo <= r_mid;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.dv_start) begin
            r_dv_rem <= '0;
            r_dv_q   <= r_s;
            r_dv_cnt <= '0;
        end
        if (i_cmd.dv_step) begin
            if (!dv_diff[S_W]) begin
                r_dv_rem <= dv_diff[S_W-1:0];
                r_dv_q   <= {r_dv_q[S_W-2:0], 1'b1};
            end else begin
                r_dv_rem <= dv_trial[S_W-1:0];
                r_dv_q   <= {r_dv_q[S_W-2:0], 1'b0};
            end
            r_dv_cnt <= r_dv_cnt + DCNT_W'(1);
        end
        if (i_cmd.nt_next) begin
            r_next <= nt_sum[S_W:1];
        end
        if (i_cmd.nt_adv) begin
            r_cur    <= r_next;
            r_nt_cnt <= r_nt_cnt + CAP_W'(1);
        end
        if (i_cmd.sq) begin
            r_nsat <= n_sat;
            r_nsq  <= n_sat * n_sat;
        end
        if (i_cmd.publish) begin
            r_res <= res_d;
        end
    end

    // vote on the three candidates
    always_comb begin
        ref_w   = BIS_W'(r_rt_res[ROOT_W-1:0]);
        nt_w    = BIS_W'(r_nsat);
        rn_ok   = absdiff(ref_w, nt_w) < BIS_W'(tol_eff);
        rb_ok   = absdiff(ref_w, r_lo) < BIS_W'(tol_eff);
        nb_ok   = absdiff(nt_w, r_lo) < BIS_W'(tol_eff);
        sq_diff = (r_nsq > (2*ROOT_W)'(r_s)) ? (r_nsq - (2*ROOT_W)'(r_s))
                                             : ((2*ROOT_W)'(r_s) - r_nsq);
        res_d.reference_root  = r_rt_res[ROOT_W-1:0];
        res_d.newton_root     = r_nsat;
        res_d.bisection_root  = r_lo[ROOT_W-1:0];
        res_d.square_check_ok = sq_diff < (2*ROOT_W)'({tol_eff, FRAC_BITS'(0)});
        if (rn_ok || rb_ok) begin
            res_d.chosen_root = r_rt_res[ROOT_W-1:0];
            res_d.verdict     = V_REFERENCE;
        end else if (nb_ok) begin
            res_d.chosen_root = r_nsat;
            res_d.verdict     = V_NEWTON;
        end else begin
            res_d.chosen_root = '0;
            res_d.verdict     = V_FAULT;
        end
    end

    assign o_res = r_res;
endmodule

// ===== hw/rtl/dsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsv_ctrl
// Controller: sequences root, bisection and Newton phases, owns handshakes.
// ----------------------------------------------------------------------------
module dsv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  dsv_pkg::t_sts i_sts,
    output dsv_pkg::t_cmd o_cmd
);
    import dsv_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_ovld;
    logic   n_ovld;
    logic   slot_free;

    assign slot_free = !r_ovld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_in_valid) n_state = ST_ROOT;
            ST_ROOT:      if (i_sts.rt_last) n_state = ST_BIS_MID;
            ST_BIS_MID:   n_state = i_sts.bis_more ? ST_BIS_MUL : ST_DIV_START;
            ST_BIS_MUL:   n_state = ST_BIS_UPD;
            ST_BIS_UPD:   n_state = ST_BIS_MID;
            ST_DIV_START: n_state = ST_DIV;
            ST_DIV:       if (i_sts.dv_last) n_state = ST_NT_NEXT;
            ST_NT_NEXT:   n_state = ST_NT_CHK;
            ST_NT_CHK:    n_state = i_sts.nt_more ? ST_DIV_START : ST_SQUARE;
            ST_SQUARE:    n_state = ST_VOTE;
            ST_VOTE:      if (slot_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ROOT:      o_cmd.rt_step  = 1'b1;
            ST_BIS_MID:   o_cmd.bis_mid  = 1'b1;
            ST_BIS_MUL:   o_cmd.bis_mul  = 1'b1;
            ST_BIS_UPD:   o_cmd.bis_upd  = 1'b1;
            ST_DIV_START: o_cmd.dv_start = 1'b1;
            ST_DIV:       o_cmd.dv_step  = 1'b1;
            ST_NT_NEXT:   o_cmd.nt_next  = 1'b1;
            ST_NT_CHK:    o_cmd.nt_adv   = i_sts.nt_more;
            ST_SQUARE:    o_cmd.sq       = 1'b1;
            ST_VOTE:      o_cmd.publish  = slot_free;
            default: ;
        endcase
    end

    always_comb begin
        n_ovld = r_ovld;
        if (o_cmd.publish) begin
            n_ovld = 1'b1;
        end else if (i_out_ready) begin
            n_ovld = 1'b0;
        end
    end

    assign o_out_valid = r_ovld;
endmodule

// ===== hw/rtl/diverse_sqrt_voter.sv =====
// ----------------------------------------------------------------------------
// diverse_sqrt_voter
// Square root of an unsigned Q16.16 value computed three ways and voted.
// ----------------------------------------------------------------------------
// Sequence: a digit-by-digit reference root, bisection halvings, then N Newton
//   steps (1 to the iteration cap); the radix-2 divider inside each Newton
//   step dominates.
// Throughput: one transaction at a time; the next radicand is taken while a
//   finished result still waits in the output register.
// Reset: synchronous, active low; returns to idle, drops the output valid
//   and restores tolerance 1 and iteration cap 32.
module diverse_sqrt_voter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dsv_in_if.sink                        i_rad,
    dsv_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [dsv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsv_pkg::CFG_W-1:0]     i_cfg_data
);
    import dsv_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    // Controller: walks reference root, bisection, then Newton steps, and
    // holds the result valid until the sink takes the transaction.
    dsv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_rad.valid),
        .o_in_ready  (i_rad.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: all arithmetic, configuration registers and result register.
    dsv_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_radicand (i_rad.radicand),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_res      (res)
    );

    // Drive the result channel straight from the result register.
    assign o_res.chosen_root     = res.chosen_root;
    assign o_res.reference_root  = res.reference_root;
    assign o_res.newton_root     = res.newton_root;
    assign o_res.bisection_root  = res.bisection_root;
    assign o_res.verdict         = res.verdict;
    assign o_res.square_check_ok = res.square_check_ok;
endmodule

// ===== hw/rtl/dsv_checker.sv =====
// ----------------------------------------------------------------------------
// dsv_checker
// Port-level checks on the voter's handshakes and result consistency.
// ----------------------------------------------------------------------------
module dsv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dsv_pkg::ROOT_W-1:0]  i_chosen,
    input logic [dsv_pkg::ROOT_W-1:0]  i_reference,
    input logic [dsv_pkg::ROOT_W-1:0]  i_newton,
    input logic [1:0]                  i_verdict
);
    import dsv_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("ready high right after accepting a transaction");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_verdict == V_FAULT) |-> (i_chosen == '0))
        else $error("fault with nonzero chosen root");

    a_ref_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_verdict == V_REFERENCE) |-> (i_chosen == i_reference))
        else $error("reference verdict without reference root");

    a_newton_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_verdict == V_NEWTON) |-> (i_chosen == i_newton))
        else $error("Newton verdict without Newton root");
endmodule

bind diverse_sqrt_voter dsv_checker u_dsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rad.valid),
    .i_in_ready  (i_rad.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_chosen    (o_res.chosen_root),
    .i_reference (o_res.reference_root),
    .i_newton    (o_res.newton_root),
    .i_verdict   (o_res.verdict)
);
